/* rtl/estm_pkg.sv */
// Package for the Euler z-x-z model matrix core: payload structs, CORDIC table.
// No dependencies.
package estm_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

  typedef enum logic [1:0] {
    MODE_OWN    = 2'd0,
    MODE_PARENT = 2'd1,
    MODE_STORE  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        angle_phi;
    logic [15:0]        angle_theta;
    logic [15:0]        angle_psi;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [23:0] offset_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col_0;
    logic signed [31:0] col_1;
    logic signed [31:0] col_2;
    logic signed [31:0] col_3;
    logic               last_row;
  } out_item_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    begin
      case (i)
        5'd0:  v = 34'sd536870912;  5'd1:  v = 34'sd316933406;
        5'd2:  v = 34'sd167458907;  5'd3:  v = 34'sd85004756;
        5'd4:  v = 34'sd42667331;   5'd5:  v = 34'sd21354465;
        5'd6:  v = 34'sd10679838;   5'd7:  v = 34'sd5340245;
        5'd8:  v = 34'sd2670163;    5'd9:  v = 34'sd1335087;
        5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
        5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
        5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
        5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
        5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
        5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
        5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Q30 product with rounding, inputs within +-2^31
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = a * b + 68'sd536870912;
      return 34'(p >>> 30);
    end
  endfunction

endpackage

/* rtl/euler_scale_translate_matrix_core.sv */
// Top level of the Euler z-x-z model matrix core.
// Depends on estm_pkg and estm_cordic.
//
// Usage:
//   in_*  : one request per transform (mode, three angles, scales, offsets).
//   out_* : four row requests per mode 0/1 transform, rows 0..3, last_row on 3.
//   Mode 2 loads the parent store and yields nothing; mode 3 is dropped.
// Structure:
//   stage 0 registers the request and adds the parent (saturating offsets);
//   24 CORDIC stages, two rotation-product stages and a scale stage follow,
//   one register level each, all advanced together by a common enable.
//   A row serialiser then emits the matrix as four rows.
// Throughput: limited by the single result port carrying four rows per
//   transform; the pipeline accepts one request per cycle until a
//   valid request sits in the last stage while the serialiser is still busy.
// Reset: parent store cleared to zero, all valid bits cleared.
// Stall: when out_ready is low the serialiser holds its row; the whole pipe
//   holds while its last stage carries a request the serialiser cannot take,
//   so nothing is lost or repeated.
module euler_scale_translate_matrix_core
  import estm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // carried alongside the CORDIC
  typedef struct packed {
    logic signed [23:0] sx, sy, sz;
    logic signed [23:0] ox, oy, oz;
  } side_t;

  localparam int CORDIC_LEN = CORDIC_STEPS;
  localparam int NST = CORDIC_LEN + 4;  // front, cordic, p1, p2, scale

  logic [NST-1:0] vld_r;
  logic           adv;
  logic           ser_free;

  // ---------------- parent store ----------------
  logic [15:0]        par_phi_r, par_th_r, par_psi_r;
  logic signed [23:0] par_ox_r, par_oy_r, par_oz_r;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607)       return 24'sd8388607;
    else if (v < -25'sd8388608) return -24'sd8388608;
    else                        return 24'(v);
  endfunction

  // the whole pipe moves when the serialiser can take the tail item
  assign adv      = !vld_r[NST-1] || ser_free;
  assign in_ready = adv;

  logic acc;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_phi_r <= '0; par_th_r <= '0; par_psi_r <= '0;
      par_ox_r  <= '0; par_oy_r <= '0; par_oz_r  <= '0;
    end else if (acc && mode_t'(in_data.mode) == MODE_STORE) begin
      par_phi_r <= in_data.angle_phi;  par_th_r <= in_data.angle_theta;
      par_psi_r <= in_data.angle_psi;
      par_ox_r  <= in_data.offset_x;   par_oy_r <= in_data.offset_y;
      par_oz_r  <= in_data.offset_z;
    end
  end

  // ---------------- stage 0: combine with parent ----------------
  logic [15:0]  ang_nxt [3];
  side_t        side_nxt;
  logic         go_nxt;

  always_comb begin
    go_nxt = (mode_t'(in_data.mode) == MODE_OWN) || (mode_t'(in_data.mode) == MODE_PARENT);
    ang_nxt[0] = in_data.angle_phi;
    ang_nxt[1] = in_data.angle_theta;
    ang_nxt[2] = in_data.angle_psi;
    side_nxt.sx = in_data.scale_x;
    side_nxt.sy = in_data.scale_y;
    side_nxt.sz = in_data.scale_z;
    side_nxt.ox = in_data.offset_x;
    side_nxt.oy = in_data.offset_y;
    side_nxt.oz = in_data.offset_z;
    if (mode_t'(in_data.mode) == MODE_PARENT) begin
      ang_nxt[0] = in_data.angle_phi + par_phi_r;
      ang_nxt[1] = in_data.angle_theta + par_th_r;
      ang_nxt[2] = in_data.angle_psi + par_psi_r;
      side_nxt.ox = sat24(25'(in_data.offset_x) + 25'(par_ox_r));
      side_nxt.oy = sat24(25'(in_data.offset_y) + 25'(par_oy_r));
      side_nxt.oz = sat24(25'(in_data.offset_z) + 25'(par_oz_r));
    end
  end

  logic [15:0] ang_r [3];
  side_t       side_r [NST];
  logic [1:0]  quad_r [CORDIC_LEN][3];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], acc && go_nxt};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r     <= ang_nxt;
      side_r[0] <= side_nxt;
      for (int s = 1; s < NST; s++) side_r[s] <= side_r[s-1];
    end
  end

  // ---------------- CORDIC chain ----------------
  logic signed [33:0] cx [CORDIC_LEN+1][3];
  logic signed [33:0] cy [CORDIC_LEN+1][3];
  logic signed [33:0] cz [CORDIC_LEN+1][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cx[0][k] = CORDIC_GAIN_INV;
      cy[0][k] = '0;
      cz[0][k] = {4'b0, ang_r[k][13:0], 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) quad_r[0][k] <= ang_r[k][15:14];
      for (int s = 1; s < CORDIC_LEN; s++) quad_r[s] <= quad_r[s-1];
    end
  end

  for (genvar g = 0; g < CORDIC_LEN; g++) begin : g_cordic
    estm_cordic #(.STEP(g)) u_step (
      .clk (clk),
      .en  (adv),
      .x_i (cx[g]),  .y_i (cy[g]),  .z_i (cz[g]),
      .x_o (cx[g+1]), .y_o (cy[g+1]), .z_o (cz[g+1])
    );
  end

  // quadrant fix-up: index 0 phi, 1 theta, 2 psi
  logic signed [33:0] cs_c [3];
  logic signed [33:0] cs_s [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (quad_r[CORDIC_LEN-1][k])
        2'd0: begin cs_c[k] = cx[CORDIC_LEN][k];  cs_s[k] = cy[CORDIC_LEN][k];  end
        2'd1: begin cs_c[k] = -cy[CORDIC_LEN][k]; cs_s[k] = cx[CORDIC_LEN][k];  end
        2'd2: begin cs_c[k] = -cx[CORDIC_LEN][k]; cs_s[k] = -cy[CORDIC_LEN][k]; end
        default: begin cs_c[k] = cy[CORDIC_LEN][k]; cs_s[k] = -cx[CORDIC_LEN][k]; end
      endcase
    end
  end

  // ---------------- product stage 1 ----------------
  logic signed [33:0] cph_r, sph_r, cth_r, sth_r;
  logic signed [33:0] a_cpscph_r, a_cpssph_r, a_spscph_r, a_spssph_r;
  logic signed [33:0] a_spscth_r, a_cpscth_r, r02_r, r12_r, r20_r, r21_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cph_r <= cs_c[0]; sph_r <= cs_s[0]; cth_r <= cs_c[1]; sth_r <= cs_s[1];
      a_cpscph_r <= mul_q30(cs_c[2], cs_c[0]);
      a_cpssph_r <= mul_q30(cs_c[2], cs_s[0]);
      a_spscph_r <= mul_q30(cs_s[2], cs_c[0]);
      a_spssph_r <= mul_q30(cs_s[2], cs_s[0]);
      a_spscth_r <= mul_q30(cs_s[2], cs_c[1]);
      a_cpscth_r <= mul_q30(cs_c[2], cs_c[1]);
      r02_r <= mul_q30(cs_s[2], cs_s[1]);
      r12_r <= -mul_q30(cs_c[2], cs_s[1]);
      r20_r <= mul_q30(cs_s[1], cs_s[0]);
      r21_r <= mul_q30(cs_s[1], cs_c[0]);
    end
  end

  // ---------------- product stage 2 ----------------
  logic signed [33:0] rot_r [3][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r[0][0] <= a_cpscph_r - mul_q30(a_spscth_r, sph_r);
      rot_r[0][1] <= -a_cpssph_r - mul_q30(a_spscth_r, cph_r);
      rot_r[0][2] <= r02_r;
      rot_r[1][0] <= a_spscph_r + mul_q30(a_cpscth_r, sph_r);
      rot_r[1][1] <= -a_spssph_r + mul_q30(a_cpscth_r, cph_r);
      rot_r[1][2] <= r12_r;
      rot_r[2][0] <= r20_r;
      rot_r[2][1] <= r21_r;
      rot_r[2][2] <= cth_r;
    end
  end

  // ---------------- scale stage ----------------
  function automatic logic signed [31:0] scale32(input logic signed [33:0] r,
                                                 input logic signed [23:0] s);
    logic signed [59:0] p;
    logic signed [33:0] v;
    begin
      p = r * s + 60'sd536870912;
      v = 34'(p >>> 30);
      if (v > 34'sd2147483647)       return 32'sh7FFFFFFF;
      else if (v < -34'sd2147483648) return 32'sh80000000;
      else return 32'(v);
    end
  endfunction

  side_t              sd;
  logic signed [31:0] el_nxt [3][3];
  assign sd = side_r[NST-2];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      el_nxt[r][0] = scale32(rot_r[r][0], sd.sx);
      el_nxt[r][1] = scale32(rot_r[r][1], sd.sy);
      el_nxt[r][2] = scale32(rot_r[r][2], sd.sz);
    end
  end

  logic signed [31:0] el_r [3][3];
  always_ff @(posedge clk) begin
    if (adv) el_r <= el_nxt;
  end

  // ---------------- row serialiser ----------------
  logic signed [31:0] hold_r [3][3];
  side_t              hside_r;
  logic               busy_r;
  logic [1:0]         row_r;
  logic               fire;

  assign fire     = out_valid && out_ready;
  assign ser_free = !busy_r || (fire && row_r == 2'd3);
  assign out_valid = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else begin
      if (ser_free) begin
        busy_r <= vld_r[NST-1];
        row_r  <= '0;
      end else if (fire) begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free) begin
      hold_r  <= el_r;
      hside_r <= side_r[NST-1];
    end
  end

  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == 2'd3);
    case (row_r)
      2'd0: begin
        out_data.col_0 = hold_r[0][0]; out_data.col_1 = hold_r[0][1];
        out_data.col_2 = hold_r[0][2]; out_data.col_3 = 32'(hside_r.ox);
      end
      2'd1: begin
        out_data.col_0 = hold_r[1][0]; out_data.col_1 = hold_r[1][1];
        out_data.col_2 = hold_r[1][2]; out_data.col_3 = 32'(hside_r.oy);
      end
      2'd2: begin
        out_data.col_0 = hold_r[2][0]; out_data.col_1 = hold_r[2][1];
        out_data.col_2 = hold_r[2][2]; out_data.col_3 = 32'(hside_r.oz);
      end
      default: begin
        out_data.col_0 = '0; out_data.col_1 = '0;
        out_data.col_2 = '0; out_data.col_3 = 32'sd65536;
      end
    endcase
  end

endmodule

/* rtl/estm_cordic.sv */
// Pipelined rotation-mode CORDIC: three angles side by side, fixed step per stage.
// Depends on estm_pkg.
module estm_cordic
  import estm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [33:0]  x_i [3],
  input  logic signed [33:0]  y_i [3],
  input  logic signed [33:0]  z_i [3],
  output logic signed [33:0]  x_o [3],
  output logic signed [33:0]  y_o [3],
  output logic signed [33:0]  z_o [3]
);

  logic signed [33:0] x_nxt [3];
  logic signed [33:0] y_nxt [3];
  logic signed [33:0] z_nxt [3];
  logic signed [33:0] x_r [3];
  logic signed [33:0] y_r [3];
  logic signed [33:0] z_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_i[k][33]) begin
        x_nxt[k] = x_i[k] - (y_i[k] >>> STEP);
        y_nxt[k] = y_i[k] + (x_i[k] >>> STEP);
        z_nxt[k] = z_i[k] - atan_lut(5'(STEP));
      end else begin
        x_nxt[k] = x_i[k] + (y_i[k] >>> STEP);
        y_nxt[k] = y_i[k] - (x_i[k] >>> STEP);
        z_nxt[k] = z_i[k] + atan_lut(5'(STEP));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

/* dv/euler_scale_translate_matrix_core_test.sv */
// Self-checking bench for euler_scale_translate_matrix_core: drives transform requests,
// predicts the four matrix rows per request and compares them in order.
// Depends on estm_pkg and the core RTL.
`timescale 1ns / 100ps

module euler_scale_translate_matrix_core_test;
  import estm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  euler_scale_translate_matrix_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout: far above the slowest legal run.
  initial begin
    #20ms;
    $display("euler_scale_translate_matrix_core_test: done, errors");
    $finish;
  end

  // Predictor state: copy of the parent store
  logic [15:0]        par_phi, par_theta, par_psi;
  logic signed [23:0] par_off_x, par_off_y, par_off_z;

  out_item_t rows_due[$];
  int        n_errors = 0;
  int        n_reqs = 0;

  // Idling controls
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  bit  hold_off_req = 1'b0;
  bit  hold_off_taken = 1'b0;

  // Arithmetic shift with floor semantics on 64-bit values
  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // CORDIC sine/cosine in Q30, bit-exact with the datapath
  task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy;
    a = {ang, 16'h0};
    quad = a[31:30];
    x = 652032874;
    y = 0;
    z = longint'(a & 32'h3FFF_FFFF);
    for (int i = 0; i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(5'(i)));
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [23:0] sat_offset(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  function automatic logic signed [31:0] scale_elem(longint r, longint sc);
    longint v;
    v = floor_shr(r * sc + (64'sd1 <<< 29), 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  // Works out the matrix rows a request yields and queues them
  task automatic predict_matrix(input in_item_t rq);
    logic [15:0]        phi, th, ps;
    logic signed [23:0] off [3];
    longint             sc [3];
    longint             rot [3][3];
    longint             cph, sph, cth, sth, cps, sps;
    out_item_t          row;
    phi = rq.angle_phi; th = rq.angle_theta; ps = rq.angle_psi;
    off[0] = rq.offset_x; off[1] = rq.offset_y; off[2] = rq.offset_z;
    sc[0] = rq.scale_x; sc[1] = rq.scale_y; sc[2] = rq.scale_z;
    case (mode_t'(rq.mode))
      MODE_NONE: return;
      MODE_STORE: begin
        par_phi = phi; par_theta = th; par_psi = ps;
        par_off_x = off[0]; par_off_y = off[1]; par_off_z = off[2];
        return;
      end
      MODE_PARENT: begin
        phi += par_phi; th += par_theta; ps += par_psi;
        off[0] = sat_offset(longint'(off[0]) + longint'(par_off_x));
        off[1] = sat_offset(longint'(off[1]) + longint'(par_off_y));
        off[2] = sat_offset(longint'(off[2]) + longint'(par_off_z));
      end
      default: ;
    endcase
    sin_cos(phi, cph, sph);
    sin_cos(th, cth, sth);
    sin_cos(ps, cps, sps);
    rot[0][0] = q30_mul(cps, cph) - q30_mul(q30_mul(sps, cth), sph);
    rot[0][1] = -q30_mul(cps, sph) - q30_mul(q30_mul(sps, cth), cph);
    rot[0][2] = q30_mul(sps, sth);
    rot[1][0] = q30_mul(sps, cph) + q30_mul(q30_mul(cps, cth), sph);
    rot[1][1] = -q30_mul(sps, sph) + q30_mul(q30_mul(cps, cth), cph);
    rot[1][2] = -q30_mul(cps, sth);
    rot[2][0] = q30_mul(sth, sph);
    rot[2][1] = q30_mul(sth, cph);
    rot[2][2] = cth;
    for (int r = 0; r < 3; r++) begin
      row.row_index = 2'(r);
      row.col_0 = scale_elem(rot[r][0], sc[0]);
      row.col_1 = scale_elem(rot[r][1], sc[1]);
      row.col_2 = scale_elem(rot[r][2], sc[2]);
      row.col_3 = 32'(off[r]);
      row.last_row = 1'b0;
      rows_due.push_back(row);
    end
    row = '{row_index: 2'd3, col_0: 0, col_1: 0, col_2: 0, col_3: 32'sd65536,
            last_row: 1'b1};
    rows_due.push_back(row);
  endtask

  // Directed table. Where a row set can be read straight off, the expected
  // first row is given; other rows are left to the predictor.
  typedef struct {
    in_item_t  rq;
    logic      has_row0;
    out_item_t row0;
  } dir_row_t;

  localparam logic signed [23:0] ONE = 24'sh010000;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = 24'sh800000;

  dir_row_t dir_tab[$];

  function automatic in_item_t mk(mode_t md, logic [15:0] ph, logic [15:0] th,
                                  logic [15:0] ps, logic signed [23:0] sx,
                                  logic signed [23:0] sy, logic signed [23:0] sz,
                                  logic signed [23:0] ox, logic signed [23:0] oy,
                                  logic signed [23:0] oz);
    return '{mode: md, angle_phi: ph, angle_theta: th, angle_psi: ps,
             scale_x: sx, scale_y: sy, scale_z: sz,
             offset_x: ox, offset_y: oy, offset_z: oz};
  endfunction

  initial begin
    // identity-ish, zero angles, scale one: row 0 = (cos*1, 0, 0, offset)
    dir_tab.push_back('{mk(MODE_OWN, 0, 0, 0, ONE, ONE, ONE, 24'sd5, 24'sd6, 24'sd7),
                        1'b0, '0});
    // zero scale: row 0 is all zero but for the offset
    dir_tab.push_back('{mk(MODE_OWN, 16'h1234, 16'h4321, 16'hABCD, 0, 0, 0,
                           CMAX, CMIN, 0), 1'b1,
                        '{2'd0, 0, 0, 0, 32'sd8388607, 1'b0}});
    // parent before any store: reset parent is zero
    dir_tab.push_back('{mk(MODE_PARENT, 16'h4000, 16'h8000, 16'hC000, ONE, ONE, ONE,
                           1, 2, 3), 1'b0, '0});
    // unused mode, then store, which are both silent
    dir_tab.push_back('{mk(MODE_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, CMAX, CMAX, CMAX,
                           CMAX, CMAX, CMAX), 1'b0, '0});
    dir_tab.push_back('{mk(MODE_STORE, 16'hFFFF, 16'h8000, 16'h0001, CMIN, CMIN, CMIN,
                           CMAX, CMIN, CMAX), 1'b0, '0});
    // parent sum: angles wrap, offsets saturate both ways
    dir_tab.push_back('{mk(MODE_PARENT, 16'h0001, 16'h8000, 16'hFFFF, ONE, ONE, ONE,
                           CMAX, CMIN, 0), 1'b0, '0});
    // full-range scales of both signs
    dir_tab.push_back('{mk(MODE_OWN, 0, 0, 0, CMAX, CMIN, CMAX, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk(MODE_OWN, 16'h8000, 16'h8000, 16'h8000, CMIN, CMAX, CMIN,
                           CMIN, CMIN, CMIN), 1'b0, '0});
    // quadrant boundaries
    for (int k = 0; k < 4; k++)
      dir_tab.push_back('{mk(MODE_OWN, 16'(k * 16'h4000), 16'(k * 16'h4000 + 16'h3FFF),
                             16'(16'hFFFF - k * 16'h4000), ONE, -ONE, ONE,
                             24'(k), 24'(-k), 0), 1'b0, '0});
    dir_tab.push_back('{mk(MODE_STORE, 16'h1111, 16'h2222, 16'h3333, 0, 0, 0,
                           24'sh100000, -24'sh100000, 24'sh000123), 1'b0, '0});
    dir_tab.push_back('{mk(MODE_PARENT, 16'h7000, 16'h7000, 16'h7000, ONE, ONE, ONE,
                           24'sh010000, 24'sh020000, 24'sh030000), 1'b0, '0});
  end

  // Offers one request and waits until it is taken; valid only drops for idling
  task automatic offer_request(input in_item_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_matrix(rq);
    n_reqs++;
  endtask

  function automatic in_item_t random_request();
    in_item_t     rq;
    logic [223:0] raw;
    int           pick;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    rq = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    rq.mode = pick < 45 ? MODE_OWN : pick < 80 ? MODE_PARENT :
              pick < 95 ? MODE_STORE : MODE_NONE;
    // mostly sensible scales, some full range
    if ($urandom_range(3) != 0) begin
      rq.scale_x = 24'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      rq.scale_y = 24'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      rq.scale_z = 24'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
    end
    return rq;
  endfunction

  // Receiver: random stall plus a one-off long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken  <= 1'b1;
      hold_off_cycles <= 299;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Row checker
  always @(posedge clk) begin
    out_item_t exp_row;
    if (rst_n && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected row: %p", out_data);
      end else begin
        exp_row = rows_due.pop_front();
        if (out_data !== exp_row) begin
          n_errors++;
          if (n_errors <= 10)
            $display("row mismatch: expected %p, got %p", exp_row, out_data);
        end
      end
    end
  end

  task automatic drain_rows();
    while (rows_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    par_phi = 0; par_theta = 0; par_psi = 0;
    par_off_x = 0; par_off_y = 0; par_off_z = 0;
    phase_idle  = '{0, 84, 0, 36};
    phase_stall = '{0, 0, 84, 36};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      offer_request(dir_tab[i].rq);
      if (dir_tab[i].has_row0) begin
        // first of the four queued rows must match the typed-in row
        if (rows_due[rows_due.size() - 4] !== dir_tab[i].row0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("table row 0: expected %p, predicted %p", dir_tab[i].row0,
                     rows_due[rows_due.size() - 4]);
        end
      end
    end

    // Fill the pipeline behind a stalled receiver
    hold_off_req = 1'b1;
    repeat (40) offer_request(random_request());

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      repeat (32) offer_request(random_request());
      // sender pauses until all rows are back
      in_valid <= 1'b0;
      drain_rows();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_rows();
    repeat (60) @(posedge clk);
    if (n_errors == 0)
      $display("euler_scale_translate_matrix_core_test: done, clean");
    else
      $display("euler_scale_translate_matrix_core_test: done, errors");
    $finish;
  end

endmodule
